[design/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// ASSERT_PROP checks a property at every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[design/arnl_pkg.sv]
`timescale 1ns / 1ps

package arnl_pkg;

  // Table geometry and address split.
  localparam int TABLE_ENTRIES = 8;
  localparam int PAGE_BITS     = 12;

  // Fixed field widths of the interface.
  localparam int ADDR_W        = 64;
  localparam int PFN_W         = 52;
  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 4;
  localparam int ENTRY_IDX_W   = 3;

  // Derived widths.
  localparam int PAGE_W  = ADDR_W - PAGE_BITS;
  localparam int CMP_W   = (PAGE_W > PFN_W) ? PAGE_W : PFN_W;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  // Signed search bounds must hold -1, the count minus one and the table size.
  localparam int BND_W   = $clog2(TABLE_ENTRIES + (1 << COUNT_W)) + 1;
  localparam int PRB_W   = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [PFN_W-1:0]  first_page;
    logic [PFN_W-1:0]  end_page;
    logic [NODE_W-1:0] node;
  } tbl_entry_t;

  typedef struct packed {
    logic hit;
    logic below;
    logic above;
  } cmp_res_t;

endpackage

[design/address_range_node_lookup_unit.sv]
`timescale 1ns / 1ps
// Address range to node lookup. Table writes (mode 0) store one range entry
// and are done in the cycle of their transfer; they produce no result. A
// lookup (mode 1) takes the page number of the address and binary-searches
// the first range_count entries, one probe per cycle through a single shared
// compare unit, for at most TABLE_ENTRIES probes. A hit ends the search at
// its probe, and a miss ends it with a closing step that probes no entry. The
// result is then registered and offered in ST_DONE. The input side stays
// stalled until the result transfer, and the next item can be taken in the
// cycle after the result transfer. The table entries have no reset value and
// must be written before a lookup can probe them. The user must write
// range_count through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this.

`include "assert_macros.svh"

module address_range_node_lookup_unit
  import arnl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration port.
  input  logic                   cfg_wr_en,
  input  logic [COUNT_W-1:0]     cfg_wr_data,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [ENTRY_IDX_W-1:0] entry_index,
  input  logic [PFN_W-1:0]       range_first_page,
  input  logic [PFN_W-1:0]       range_end_page,
  input  logic [NODE_W-1:0]      range_node,
  input  logic [ADDR_W-1:0]      address,
  // Output channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [NODE_W-1:0]      node
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  localparam logic signed [BND_W-1:0] BND_ONE     = BND_W'(1);
  localparam logic signed [BND_W-1:0] BND_ENTRIES = BND_W'(TABLE_ENTRIES);
  localparam logic [PRB_W-1:0]        PRB_LAST    = PRB_W'(TABLE_ENTRIES);

  state_t                   st, st_next;
  logic [COUNT_W-1:0]       range_count;
  logic [PAGE_W-1:0]        page;
  logic signed [BND_W-1:0]  lo, lo_next;
  logic signed [BND_W-1:0]  hi, hi_next;
  logic [PRB_W-1:0]         probe, probe_next;
  logic                     found_next;
  logic [NODE_W-1:0]        node_next;

  logic                     in_xfer;
  logic                     out_xfer;
  logic                     tbl_wr_en;
  tbl_entry_t               wr_entry;
  tbl_entry_t               rd_entry;
  cmp_res_t                 cmp;
  logic signed [BND_W:0]    bnd_sum;
  logic signed [BND_W-1:0]  mid;
  logic signed [BND_W-1:0]  count_s;
  logic                     stop_miss;

  // Handshake. The block takes a new item only when nothing is in flight.
  assign in_stall  = (st != ST_IDLE);
  assign out_valid = (st == ST_DONE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // Table write path. Indexes past the end of the table are dropped.
  assign tbl_wr_en = in_xfer && !mode && (32'(entry_index) < TABLE_ENTRIES);
  assign wr_entry  = '{first_page: range_first_page,
                       end_page:   range_end_page,
                       node:       range_node};

  // Probe index is the midpoint of the bounds; they are never negative when
  // the probe is used, so a plain halving of the sum is the C division.
  assign bnd_sum = {lo[BND_W-1], lo} + {hi[BND_W-1], hi};
  assign mid     = bnd_sum[BND_W:1];
  assign count_s = $signed(BND_W'(range_count));

  arnl_table u_table (
    .clk      (clk),
    .wr_en    (tbl_wr_en),
    .wr_idx   (IDX_W'(entry_index)),
    .wr_entry (wr_entry),
    .rd_idx   (mid[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  arnl_cmp u_cmp (
    .page  (page),
    .entry (rd_entry),
    .res   (cmp)
  );

  // The search gives up when it has spent its probes, when the bounds have
  // crossed, or when the midpoint lies past the entries in use or the table.
  assign stop_miss = (probe == PRB_LAST) || (lo > hi) ||
                     (mid >= count_s) || (mid >= BND_ENTRIES);

  always_comb begin
    st_next    = st;
    lo_next    = lo;
    hi_next    = hi;
    probe_next = probe;
    found_next = found;
    node_next  = node;
    case (st)
      ST_IDLE: begin
        if (in_xfer && mode) begin
          lo_next    = '0;
          hi_next    = count_s - BND_ONE;
          probe_next = '0;
          st_next    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stop_miss) begin
          found_next = 1'b0;
          node_next  = '0;
          st_next    = ST_DONE;
        end else if (cmp.hit) begin
          found_next = 1'b1;
          node_next  = rd_entry.node;
          st_next    = ST_DONE;
        end else begin
          // A page equal to a first page outside its range moves neither
          // bound, so the same entry is probed until the probes run out.
          if (cmp.below) begin
            hi_next = mid - BND_ONE;
          end
          if (cmp.above) begin
            lo_next = mid + BND_ONE;
          end
          probe_next = probe + PRB_W'(1);
        end
      end
      ST_DONE: begin
        if (out_xfer) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      range_count <= '0;
    end else begin
      st <= st_next;
      if (cfg_wr_en) begin
        range_count <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && mode) begin
      page <= address[ADDR_W-1:PAGE_BITS];
    end
    lo    <= lo_next;
    hi    <= hi_next;
    probe <= probe_next;
    found <= found_next;
    node  <= node_next;
  end

  `ASSERT_PROP(a_busy_while_result, clk, rst, out_valid |-> in_stall, "input taken while result pending")
  `ASSERT_PROP(a_lookup_starts, clk, rst, (in_xfer && mode) |=> (st == ST_SEARCH), "lookup did not start search")
  `ASSERT_PROP(a_write_no_result, clk, rst, (in_xfer && !mode) |=> (st == ST_IDLE), "table write left idle")
  `ASSERT_NEVER(a_probe_bound, clk, rst, (st == ST_SEARCH) && (probe > PRB_LAST), "probe count past limit")
  `ASSERT_NEVER(a_miss_node_zero, clk, rst, out_valid && !found && (node != '0), "miss with nonzero node")

endmodule

[design/arnl_table.sv]
`timescale 1ns / 1ps

module arnl_table
  import arnl_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  tbl_entry_t       wr_entry,
  input  logic [IDX_W-1:0] rd_idx,
  output tbl_entry_t       rd_entry
);

  // Small register file: one write port, one read port at the probe index.
  tbl_entry_t entries [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_idx] <= wr_entry;
    end
  end

  assign rd_entry = entries[rd_idx];

endmodule

[design/arnl_cmp.sv]
`timescale 1ns / 1ps

module arnl_cmp
  import arnl_pkg::*;
(
  input  logic [PAGE_W-1:0] page,
  input  tbl_entry_t        entry,
  output cmp_res_t          res
);

  logic [CMP_W-1:0] page_x;
  logic [CMP_W-1:0] first_x;
  logic [CMP_W-1:0] end_x;

  assign page_x  = CMP_W'(page);
  assign first_x = CMP_W'(entry.first_page);
  assign end_x   = CMP_W'(entry.end_page);

  // A reversed range never satisfies both halves, so it holds no page.
  assign res.hit   = (page_x >= first_x) && (page_x < end_x);
  assign res.below = (page_x < first_x);
  assign res.above = (page_x > first_x);

endmodule
